>>> hdl/ordf_pkg.sv
// Shared types and constants of the order record deframer.
package ordf_pkg;

    // Record tags.
    localparam logic [7:0] TAG_LIMIT  = 8'h01;
    localparam logic [7:0] TAG_MARKET = 8'h02;
    localparam logic [7:0] TAG_IOC    = 8'h03;
    localparam logic [7:0] TAG_CXL    = 8'h04;
    localparam logic [7:0] TAG_AMEND  = 8'h05;

    // Payload lengths in bytes per layout.
    localparam logic [31:0] LEN_PRICED  = 32'(1 + 8 + 1 + 8 + 8);
    localparam logic [31:0] LEN_MARKET  = 32'(1 + 8 + 1 + 8);
    localparam logic [31:0] LEN_CANCEL  = 32'(1 + 8);
    localparam logic [31:0] LEN_REPLACE = 32'(1 + 8 + 8 + 8 + 8);

    localparam logic [15:0] MAX_LEN_RESET = 16'd1024;

    // Data fields of an event on the output bus: 33 whole bytes, no padding.
    localparam int OUT_BITS = 64 + 64 + 8 + 64 + 64;

    typedef enum logic [3:0] {
        EV_LIMIT     = 4'd0,
        EV_MARKET    = 4'd1,
        EV_IOC       = 4'd2,
        EV_CANCEL    = 4'd3,
        EV_REPLACE   = 4'd4,
        EV_CLEAN_END = 4'd5,
        EV_TRUNCATED = 4'd6,
        EV_BAD_LEN   = 4'd7,
        EV_BAD_TAG   = 4'd8,
        EV_MISMATCH  = 4'd9
    } t_kind;

    // First member sits in the top bits, so event_kind lands at bit 0.
    typedef struct packed {
        logic signed [63:0] quantity;
        logic signed [63:0] price;
        logic signed [7:0]  side;
        logic [63:0]        new_order_id;
        logic [63:0]        order_id;
        t_kind              event_kind;
    } t_event;

    typedef struct packed {
        logic   vld;
        t_event ev;
    } t_res;

endpackage

>>> hdl/ordf_decode.sv
// Record parser: prefix and payload tracking, field assembly, event decode.
module ordf_decode
    import ordf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic [7:0]  i_byte,
    input  logic        i_eos,
    input  logic [15:0] i_max_len,
    output t_res        o_res
);

    typedef enum logic [1:0] {
        PH_LENGTH,
        PH_PAYLOAD,
        PH_HALTED
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [15:0] r_pos, n_pos;
    logic [31:0] r_len, n_len;
    logic [7:0]  r_tag, n_tag;
    logic [63:0] r_id0, n_id0;
    logic [63:0] r_id1, n_id1;
    logic [7:0]  r_side, n_side;
    logic [63:0] r_price, n_price;
    logic [63:0] r_qty, n_qty;

    logic        last;
    logic        known;
    logic [31:0] want;
    t_kind       kind;

    // Drop byte b into lane (pos - start) when pos falls inside the field.
    function automatic logic [63:0] put_le(logic [63:0] acc, logic [15:0] pos,
                                           logic [15:0] start, logic [7:0] b);
        logic [63:0] res;
        res = acc;
        for (int k = 0; k < 8; k++) begin
            if (pos == start + 16'(k)) begin
                res[8*k +: 8] = b;
            end
        end
        return res;
    endfunction

    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_len   = r_len;
        n_tag   = r_tag;
        n_id0   = r_id0;
        n_id1   = r_id1;
        n_side  = r_side;
        n_price = r_price;
        n_qty   = r_qty;
        o_res   = '0;
        last    = 1'b0;
        known   = 1'b1;
        want    = LEN_PRICED;
        kind    = EV_LIMIT;

        if (i_step && r_phase != PH_HALTED) begin
            if (i_eos) begin
                o_res.vld           = 1'b1;
                o_res.ev.event_kind = (r_phase == PH_LENGTH && r_pos == 16'd0)
                                      ? EV_CLEAN_END : EV_TRUNCATED;
                n_phase = PH_LENGTH;
                n_pos   = 16'd0;
                n_len   = 32'd0;
            end else if (r_phase == PH_LENGTH) begin
                if (r_pos[1:0] == 2'd0) begin
                    n_len = {24'd0, i_byte};
                end else begin
                    n_len[8*r_pos[1:0] +: 8] = i_byte;
                end
                if (r_pos[1:0] != 2'd3) begin
                    n_pos = {14'd0, r_pos[1:0]} + 16'd1;
                end else if (n_len == 32'd0 || n_len > {16'd0, i_max_len}) begin
                    n_phase             = PH_HALTED;
                    o_res.vld           = 1'b1;
                    o_res.ev.event_kind = EV_BAD_LEN;
                end else begin
                    n_phase = PH_PAYLOAD;
                    n_pos   = 16'd0;
                end
            end else begin
                if (r_pos == 16'd0) begin
                    n_tag   = i_byte;
                    n_id0   = '0;
                    n_id1   = '0;
                    n_side  = '0;
                    n_price = '0;
                    n_qty   = '0;
                end else begin
                    case (r_tag)
                        TAG_LIMIT, TAG_IOC: begin
                            n_id0   = put_le(r_id0, r_pos, 16'd1, i_byte);
                            n_price = put_le(r_price, r_pos, 16'd10, i_byte);
                            n_qty   = put_le(r_qty, r_pos, 16'd18, i_byte);
                            if (r_pos == 16'd9) begin
                                n_side = i_byte;
                            end
                        end
                        TAG_MARKET: begin
                            n_id0 = put_le(r_id0, r_pos, 16'd1, i_byte);
                            n_qty = put_le(r_qty, r_pos, 16'd10, i_byte);
                            if (r_pos == 16'd9) begin
                                n_side = i_byte;
                            end
                        end
                        TAG_CXL: begin
                            n_id0 = put_le(r_id0, r_pos, 16'd1, i_byte);
                        end
                        TAG_AMEND: begin
                            n_id0   = put_le(r_id0, r_pos, 16'd1, i_byte);
                            n_id1   = put_le(r_id1, r_pos, 16'd9, i_byte);
                            n_price = put_le(r_price, r_pos, 16'd17, i_byte);
                            n_qty   = put_le(r_qty, r_pos, 16'd25, i_byte);
                        end
                        default: ;
                    endcase
                end

                last = ({16'd0, r_pos} + 32'd1) >= r_len;

                unique case (n_tag)
                    TAG_LIMIT:  begin want = LEN_PRICED;  kind = EV_LIMIT;   end
                    TAG_MARKET: begin want = LEN_MARKET;  kind = EV_MARKET;  end
                    TAG_IOC:    begin want = LEN_PRICED;  kind = EV_IOC;     end
                    TAG_CXL:    begin want = LEN_CANCEL;  kind = EV_CANCEL;  end
                    TAG_AMEND:  begin want = LEN_REPLACE; kind = EV_REPLACE; end
                    default:    known = 1'b0;
                endcase

                if (!last) begin
                    n_pos = r_pos + 16'd1;
                end else begin
                    o_res.vld = 1'b1;
                    if (!known) begin
                        n_phase             = PH_HALTED;
                        o_res.ev.event_kind = EV_BAD_TAG;
                    end else if (r_len != want) begin
                        n_phase             = PH_HALTED;
                        o_res.ev.event_kind = EV_MISMATCH;
                    end else begin
                        // Unused fields were cleared on the tag byte.
                        n_phase               = PH_LENGTH;
                        n_pos                 = 16'd0;
                        o_res.ev.event_kind   = kind;
                        o_res.ev.order_id     = n_id0;
                        o_res.ev.new_order_id = n_id1;
                        o_res.ev.side         = n_side;
                        o_res.ev.price        = n_price;
                        o_res.ev.quantity     = n_qty;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LENGTH;
            r_pos   <= 16'd0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
        end
        r_len   <= n_len;
        r_tag   <= n_tag;
        r_id0   <= n_id0;
        r_id1   <= n_id1;
        r_side  <= n_side;
        r_price <= n_price;
        r_qty   <= n_qty;
    end

endmodule

>>> hdl/ordf_obuf.sv
// Output register with one skid entry for the event stream.
module ordf_obuf
    import ordf_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_res   i_push,
    input  logic   i_ready,
    output logic   o_valid,
    output t_event o_event,
    output logic   o_full
);

    logic   r_out_vld;
    logic   r_skid_vld;
    t_event r_out;
    t_event r_skid;
    logic   out_free;

    assign out_free = !r_out_vld || i_ready;
    assign o_valid  = r_out_vld;
    assign o_event  = r_out;
    assign o_full   = r_skid_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (out_free) begin
            // Drain the skid entry first; no push arrives while it is full.
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld <= i_push.vld;
            end
        end else if (i_push.vld) begin
            r_skid_vld <= 1'b1;
        end

        if (out_free) begin
            r_out <= r_skid_vld ? r_skid : i_push.ev;
        end
        if (!out_free && i_push.vld) begin
            r_skid <= i_push.ev;
        end
    end

endmodule

>>> hdl/order_record_deframer_unit.sv
// Top level of the order record deframer: input register, parser, output buffer.
//
// Usage:
//   Slave stream carries the journal one byte per word: tdata holds the byte,
//   tlast marks end of stream (its tdata is ignored). Each record is a 4-byte
//   little-endian length followed by a tag byte and little-endian fields.
//   Master stream carries one decoded event per record, or a status event
//   (clean end, truncated, bad length, unknown tag, length mismatch); tuser
//   holds the event kind, tdata the event fields.
//   Config channel writes max_record_length; write it only while idle.
// Throughput: one byte per cycle. The parser works on a registered byte and
//   decodes it combinationally, so the input register drains each cycle while
//   the output skid entry is empty.
// Path: the accepted byte is held in the input register, decoded by the parser,
//   and the event it completes is registered in the output register or skid entry.
// Stall: when the receiver drops tready, the next event parks in the skid
//   entry; the input side then holds one more byte and stalls until it drains.
// Error: bad length, unknown tag and mismatch halt the parser; bytes are still
//   taken and dropped until reset.
// Reset: synchronous, active low; parser waits for a length prefix and the
//   length limit returns to 1024.
module order_record_deframer_unit
    import ordf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Journal bytes
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [7:0]          i_s_axis_tdata,   // [7:0] data_byte
    input  logic                i_s_axis_tlast,   // end_of_stream
    // Decoded events
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [3:0]          o_m_axis_tuser,   // [3:0] event_kind
    // [63:0] order_id, [127:64] new_order_id, [135:128] side,
    // [199:136] price, [263:200] quantity
    output logic [OUT_BITS-1:0] o_m_axis_tdata,
    // Length limit
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [15:0]         i_cfg_data
);

    logic        r_in_vld;
    logic [7:0]  r_in_byte;
    logic        r_in_eos;
    logic [15:0] r_max_len;

    logic        obuf_full;
    logic        adv;
    logic        s_accept;
    t_res        dec_res;
    t_event      out_ev;

    // Advance the held byte into the parser whenever the skid entry is free.
    assign adv             = r_in_vld && !obuf_full;
    assign o_s_axis_tready = !r_in_vld || adv;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_max_len <= MAX_LEN_RESET;
        end else begin
            if (s_accept) begin
                r_in_vld <= 1'b1;
            end else if (adv) begin
                r_in_vld <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_max_len <= i_cfg_data;
            end
        end
        if (s_accept) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_eos  <= i_s_axis_tlast;
        end
    end

    ordf_decode u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (adv),
        .i_byte    (r_in_byte),
        .i_eos     (r_in_eos),
        .i_max_len (r_max_len),
        .o_res     (dec_res)
    );

    ordf_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (dec_res),
        .i_ready (i_m_axis_tready),
        .o_valid (o_m_axis_tvalid),
        .o_event (out_ev),
        .o_full  (obuf_full)
    );

    assign o_m_axis_tuser = out_ev.event_kind;
    assign o_m_axis_tdata = {out_ev.quantity, out_ev.price, out_ev.side,
                             out_ev.new_order_id, out_ev.order_id};

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of the order record deframer: byte driver, event checker, predictor.
module tb_top
    import ordf_pkg::*;
();

    typedef enum logic [1:0] {
        PARSE_PREFIX,
        PARSE_BODY,
        PARSE_STOPPED
    } t_parse_phase;

    // Ways to end the run; each one halts the parser for good.
    typedef enum int {
        FAULT_ZERO_LEN,
        FAULT_OVER_LIMIT,
        FAULT_BAD_TAG,
        FAULT_MISMATCH
    } t_fault;

    // Decodes the accepted journal bytes on its own and holds the events still owed.
    class record_scoreboard;
        logic [15:0]  len_limit;
        t_parse_phase parse_phase;
        logic [15:0]  pos;
        logic [31:0]  rec_len;
        logic [7:0]   rec_tag;
        logic [63:0]  id_a;
        logic [63:0]  id_b;
        logic [7:0]   side_acc;
        logic [63:0]  price_acc;
        logic [63:0]  qty_acc;
        t_event       owed_events[$];
        int           mismatches;

        function new();
            len_limit   = MAX_LEN_RESET;
            parse_phase = PARSE_PREFIX;
            pos         = '0;
            rec_len     = '0;
            mismatches  = 0;
            clear_record();
        endfunction

        function void clear_record();
            rec_tag   = '0;
            id_a      = '0;
            id_b      = '0;
            side_acc  = '0;
            price_acc = '0;
            qty_acc   = '0;
        endfunction

        function void set_limit(logic [15:0] v);
            len_limit = v;
        endfunction

        function int owed();
            return owed_events.size();
        endfunction

        function void owe_status(t_kind k);
            t_event ev;
            ev = '0;
            ev.event_kind = k;
            owed_events.push_back(ev);
        endfunction

        function logic [63:0] le_insert(logic [63:0] acc, int unsigned p, int unsigned first,
                                        logic [7:0] b);
            if (p >= first && p < first + 8)
                acc[8*(p-first) +: 8] = b;
            return acc;
        endfunction

        function void store_field_byte(int unsigned p, logic [7:0] b);
            case (rec_tag)
                TAG_LIMIT, TAG_IOC: begin
                    id_a = le_insert(id_a, p, 1, b);
                    if (p == 9) side_acc = b;
                    price_acc = le_insert(price_acc, p, 10, b);
                    qty_acc   = le_insert(qty_acc, p, 18, b);
                end
                TAG_MARKET: begin
                    id_a = le_insert(id_a, p, 1, b);
                    if (p == 9) side_acc = b;
                    qty_acc = le_insert(qty_acc, p, 10, b);
                end
                TAG_CXL: begin
                    id_a = le_insert(id_a, p, 1, b);
                end
                TAG_AMEND: begin
                    id_a      = le_insert(id_a, p, 1, b);
                    id_b      = le_insert(id_b, p, 9, b);
                    price_acc = le_insert(price_acc, p, 17, b);
                    qty_acc   = le_insert(qty_acc, p, 25, b);
                end
                default: ;
            endcase
        endfunction

        // Close a record on its last payload byte.
        function void close_record();
            logic [31:0] want;
            t_kind       kind;
            t_event      ev;
            case (rec_tag)
                TAG_LIMIT:  begin want = LEN_PRICED;  kind = EV_LIMIT;   end
                TAG_MARKET: begin want = LEN_MARKET;  kind = EV_MARKET;  end
                TAG_IOC:    begin want = LEN_PRICED;  kind = EV_IOC;     end
                TAG_CXL:    begin want = LEN_CANCEL;  kind = EV_CANCEL;  end
                TAG_AMEND:  begin want = LEN_REPLACE; kind = EV_REPLACE; end
                default: begin
                    parse_phase = PARSE_STOPPED;
                    owe_status(EV_BAD_TAG);
                    return;
                end
            endcase
            if (rec_len != want) begin
                parse_phase = PARSE_STOPPED;
                owe_status(EV_MISMATCH);
                return;
            end
            parse_phase = PARSE_PREFIX;
            pos         = '0;
            // Accumulators only ever hold the fields of the tag's layout.
            ev = '0;
            ev.event_kind   = kind;
            ev.order_id     = id_a;
            ev.new_order_id = id_b;
            ev.side         = side_acc;
            ev.price        = price_acc;
            ev.quantity     = qty_acc;
            owed_events.push_back(ev);
        endfunction

        function void take_byte(logic [7:0] b, logic eos);
            int unsigned q;
            if (parse_phase == PARSE_STOPPED)
                return;
            if (eos) begin
                owe_status((parse_phase == PARSE_PREFIX && pos == 0) ? EV_CLEAN_END
                                                                      : EV_TRUNCATED);
                parse_phase = PARSE_PREFIX;
                pos         = '0;
                rec_len     = '0;
                clear_record();
                return;
            end
            if (parse_phase == PARSE_PREFIX) begin
                q = pos[1:0];
                if (q == 0) rec_len = '0;
                rec_len[8*q +: 8] = b;
                if (q < 3) begin
                    pos = 16'(q + 1);
                    return;
                end
                if (rec_len == 0 || rec_len > 32'(len_limit)) begin
                    parse_phase = PARSE_STOPPED;
                    owe_status(EV_BAD_LEN);
                    return;
                end
                parse_phase = PARSE_BODY;
                pos         = '0;
                return;
            end
            if (pos == 0) begin
                clear_record();
                rec_tag = b;
            end else begin
                store_field_byte(pos, b);
            end
            if (32'(pos) + 32'd1 >= rec_len)
                close_record();
            else
                pos = pos + 16'd1;
        endfunction

        function bit field_ok(string what, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                $display("%0t: %s expected %h got %h", $time, what, want, got);
                return 1'b0;
            end
            return 1'b1;
        endfunction

        function void match_event(logic [3:0] user, logic [OUT_BITS-1:0] word);
            t_event got;
            t_event exp_ev;
            bit     ok;
            got = t_event'({word, user});
            if (owed_events.size() == 0) begin
                $display("%0t: event with none owed, kind expected none got %0d",
                         $time, got.event_kind);
                mismatches++;
                return;
            end
            exp_ev = owed_events.pop_front();
            ok = 1'b1;
            ok &= field_ok("event_kind", 64'(exp_ev.event_kind), 64'(got.event_kind));
            ok &= field_ok("order_id", exp_ev.order_id, got.order_id);
            ok &= field_ok("new_order_id", exp_ev.new_order_id, got.new_order_id);
            ok &= field_ok("side", 64'(exp_ev.side), 64'(got.side));
            ok &= field_ok("price", exp_ev.price, got.price);
            ok &= field_ok("quantity", exp_ev.quantity, got.quantity);
            if (!ok) mismatches++;
        endfunction
    endclass

    localparam int STALL_LIMIT = 4000;   // cycles with no word moving on any channel
    localparam int HOLD_CYCLES = 300;    // long receiver hold-off

    logic                i_clk            = 1'b0;
    logic                i_rst_n          = 1'b0;
    logic                i_s_axis_tvalid  = 1'b0;
    logic                o_s_axis_tready;
    logic [7:0]          i_s_axis_tdata   = '0;
    logic                i_s_axis_tlast   = 1'b0;
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready  = 1'b0;
    logic [3:0]          o_m_axis_tuser;
    logic [OUT_BITS-1:0] o_m_axis_tdata;
    logic                i_cfg_valid      = 1'b0;
    logic                o_cfg_ready;
    logic [15:0]         i_cfg_data       = '0;

    record_scoreboard ledger;

    int src_idle   = 37;   // percent of cycles the sender sits out
    int snk_idle   = 37;   // percent of cycles the receiver drops tready
    int sink_hold  = 0;    // nonzero asks the receiver for one long hold-off
    int words_sent = 0;
    int quiet_run  = 0;

    order_record_deframer_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        ledger = new();
        forever #1 i_clk = ~i_clk;
    end

    // Check every event word the moment it is taken.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            ledger.match_event(o_m_axis_tuser, o_m_axis_tdata);
    end

    // Abort when no word moves on any channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_run <= 0;
        end else begin
            quiet_run <= quiet_run + 1;
            if (quiet_run >= STALL_LIMIT) begin
                $display("tb_top failed");
                $finish;
            end
        end
    end

    // Receiver: random tready, or one long hold-off on request.
    initial begin
        int n;
        forever begin
            @(negedge i_clk);
            if (sink_hold > 0) begin
                n = sink_hold;
                sink_hold = 0;
                i_m_axis_tready <= 1'b0;
                repeat (n - 1) @(negedge i_clk);
            end else begin
                i_m_axis_tready <= ($urandom_range(99) >= snk_idle);
            end
        end
    end

    // Favor the extreme byte values in field contents.
    function automatic logic [7:0] field_byte();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            3:       return 8'h7F;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic int unsigned layout_len(logic [7:0] tag);
        case (tag)
            TAG_LIMIT, TAG_IOC: return LEN_PRICED;
            TAG_MARKET:         return LEN_MARKET;
            TAG_CXL:            return LEN_CANCEL;
            TAG_AMEND:          return LEN_REPLACE;
            default:            return 0;
        endcase
    endfunction

    // Offer one byte word; enter and leave at a falling edge, tvalid left high.
    task automatic push_word(input logic [7:0] b, input logic eos);
        while ($urandom_range(99) < src_idle) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tlast  <= eos;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        ledger.take_byte(b, eos);
        words_sent++;
        @(negedge i_clk);
    endtask

    // Send a length prefix and body bytes; a cut >= 0 below the word count stops
    // after that many bytes and closes the stream. A fill >= 0 sets every field byte.
    task automatic send_record(input logic [7:0] tag, input logic [31:0] len,
                               input int unsigned body, input int cut, input int fill);
        logic [7:0] words[$];
        int         k;
        int         n;
        for (k = 0; k < 4; k++) words.push_back(len[8*k +: 8]);
        if (body > 0) words.push_back(tag);
        for (k = 1; k < body; k++) words.push_back(fill < 0 ? field_byte() : fill[7:0]);
        n = (cut >= 0 && cut < words.size()) ? cut : words.size();
        for (k = 0; k < n; k++) push_word(words[k], 1'b0);
        if (n < words.size()) push_word(field_byte(), 1'b1);
    endtask

    // Mostly well-formed records that fit the limit, the rest broken ones
    // cut short before their last byte (only those when no layout fits), now and then a clean end.
    task automatic send_random_record(input logic [15:0] limit);
        logic [7:0]  fits[$];
        logic [7:0]  tag;
        int unsigned len;
        for (tag = TAG_LIMIT; tag <= TAG_AMEND; tag++)
            if (layout_len(tag) <= limit) fits.push_back(tag);
        if ($urandom_range(99) < 8) push_word(field_byte(), 1'b1);
        if (fits.size() == 0 || $urandom_range(99) < 15) begin
            tag = $urandom_range(1) ? 8'($urandom_range(255)) : 8'($urandom_range(1, 5));
            len = $urandom_range(1, (limit < 64) ? limit : 64);
            send_record(tag, len, len, $urandom_range(1, 3 + len), -1);
        end else begin
            tag = fits[$urandom_range(fits.size() - 1)];
            send_record(tag, layout_len(tag), layout_len(tag), -1, -1);
        end
    endtask

    // Drop tvalid, drain every owed event, then let the pipeline settle.
    task automatic quiesce();
        i_s_axis_tvalid <= 1'b0;
        while (ledger.owed() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic program_limit(input logic [15:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        ledger.set_limit(v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [15:0] limits[7];
        logic [15:0] limit;
        logic [7:0]  tag;
        logic [31:0] len;
        int          phase_no;
        t_fault      fault;

        limits = '{16'd65535, 16'd1, 16'd33, 16'd32, 16'd26, 16'd18, 16'd9};

        // Hold reset, then release it at a falling edge.
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part under the reset limit: every tag, all but AMEND with extreme
        // fields, clean end, truncation inside the prefix and inside the payload.
        send_record(TAG_LIMIT, LEN_PRICED, LEN_PRICED, -1, 'hFF);
        send_record(TAG_MARKET, LEN_MARKET, LEN_MARKET, -1, 'h00);
        send_record(TAG_IOC, LEN_PRICED, LEN_PRICED, -1, 'h80);
        send_record(TAG_CXL, LEN_CANCEL, LEN_CANCEL, -1, 'h7F);
        send_record(TAG_AMEND, LEN_REPLACE, LEN_REPLACE, -1, -1);
        push_word(8'hFF, 1'b1);
        send_record(TAG_CXL, LEN_CANCEL, LEN_CANCEL, 2, -1);
        send_record(TAG_AMEND, LEN_REPLACE, LEN_REPLACE, 3 + LEN_REPLACE, -1);
        send_record(TAG_MARKET, LEN_MARKET, LEN_MARKET, 4, -1);
        push_word(8'h00, 1'b1);

        // Random part: one limit per phase, extremes first. Phase 2 runs
        // with no idling; phase 4 holds the receiver off to back up the block.
        phase_no = 0;
        while (words_sent < 1050) begin
            quiesce();
            if (phase_no < 7)
                limit = limits[phase_no];
            else
                limit = $urandom_range(1) ? 16'($urandom_range(9, 64))
                                          : 16'($urandom_range(65, 65535));
            program_limit(limit);
            src_idle = (phase_no == 2) ? 0 : 37;
            snk_idle = (phase_no == 2) ? 0 : 37;
            if (phase_no == 4) sink_hold = HOLD_CYCLES;
            repeat (6) send_random_record(limit);
            phase_no++;
        end

        // End on one halting fault, then check that the stopped parser stays quiet.
        // Keep the faulty payload short so the run stays near its byte budget.
        quiesce();
        limit = ($urandom_range(2) == 0) ? 16'hFFFF : 16'($urandom_range(60, 64));
        program_limit(limit);
        fault = t_fault'($urandom_range(3));
        case (fault)
            FAULT_ZERO_LEN: begin
                send_record(TAG_LIMIT, 32'd0, 0, -1, -1);
            end
            FAULT_OVER_LIMIT: begin
                len = $urandom_range(1) ? 32'(limit) + 32'd1
                                        : $urandom_range(32'hFFFF_FFFF, 32'(limit) + 32'd1);
                send_record(TAG_LIMIT, len, 0, -1, -1);
            end
            FAULT_BAD_TAG: begin
                tag = ($urandom_range(4) == 0) ? 8'h00 : 8'($urandom_range(6, 255));
                len = ($urandom_range(3) == 0 && limit <= 16'd64) ? 32'(limit)
                                                                  : $urandom_range(1, 60);
                send_record(tag, len, len, -1, -1);
            end
            FAULT_MISMATCH: begin
                tag = 8'($urandom_range(1, 5));
                do begin
                    len = ($urandom_range(3) == 0 && limit <= 16'd64) ? 32'(limit)
                                                                      : $urandom_range(1, 60);
                end while (len == layout_len(tag));
                send_record(tag, len, len, -1, -1);
            end
            default: ;
        endcase
        repeat (20) push_word(field_byte(), $urandom_range(3) == 0);

        // Drain, wait out the latency, report.
        i_s_axis_tvalid <= 1'b0;
        while (ledger.owed() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (ledger.mismatches == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

>>> filelist.f
hdl/ordf_pkg.sv
hdl/ordf_decode.sv
hdl/ordf_obuf.sv
hdl/order_record_deframer_unit.sv
tb/tb_top.sv
